@@ rtl/lsm_pkg.sv @@
// ============================================================================
// lsm_pkg - shared definitions for the latency statistics monitor
// Widths, reset values, divider sizing and the sequencer state type.
// ============================================================================
package lsm_pkg;

    // Fixed field widths
    localparam int CNT_W       = 21;
    localparam int SUM_W       = 64;
    localparam int OUT_W       = 32;
    localparam int TS_W        = 32;

    // Default tick counter width
    localparam int TIME_WIDTH_DEF = 32;

    // Auto-clear limit after reset
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1640000);

    // Divider: one quotient bit per cycle over the whole sum
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } lsm_state_t;

endpackage : lsm_pkg

@@ rtl/latency_stats_monitor_top.sv @@
// ============================================================================
// latency_stats_monitor_top - start/stop interval statistics
// Measures tick intervals, keeps count, saturating sum and maximum, and
// reports the truncated average on every measuring stop beat.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready) carries an event: command 0 is a start,
//   which latches the timestamp and returns nothing; command 1 is a stop,
//   which returns one result beat on the m_ channel.
//   cfg_wr_en/cfg_wr_data write the auto-clear limit; write it while idle.
// Timing:
//   A start beat leaves s_ready high.
//   For a measuring stop the average comes from a bit-serial divider
//   giving one quotient bit per cycle over the 64-bit sum. A clearing
//   stop skips the divider and goes straight to the write state.
//   s_ready is low from a stop until its result has been loaded into the
//   output register, so a new event may be accepted while that result
//   still waits for m_ready.
// Reset:
//   aresetn (synchronous, active low) clears count, sum, maximum, start time
//   and the clear flag, and sets the limit to 1640000.
// Stall:
//   With m_ready low the result holds; a following stop waits in the write
//   state until the output register frees.
// ============================================================================
module latency_stats_monitor_top
    import lsm_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    // Configuration
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    // Event input
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_command,
    input  logic [TS_W-1:0]  s_timestamp,
    // Result output
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_valid_res,
    output logic [OUT_W-1:0] m_elapsed,
    output logic [OUT_W-1:0] m_max_elapsed,
    output logic [OUT_W-1:0] m_average,
    output logic [CNT_W-1:0] m_sample_count,
    output logic             m_clear_pending
);

    lsm_state_t state_reg, state_next;

    logic [CNT_W-1:0]      limit_reg;
    logic [TIME_WIDTH-1:0] start_reg,   start_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [SUM_W-1:0]      sum_reg,     sum_next;
    logic [TIME_WIDTH-1:0] longest_reg, longest_next;
    logic                  pend_reg,    pend_next;
    logic [TIME_WIDTH-1:0] el_reg,      el_next;
    logic                  meas_reg,    meas_next;

    logic                  m_valid_reg;
    logic                  m_valid_res_reg;
    logic [OUT_W-1:0]      m_elapsed_reg;
    logic [OUT_W-1:0]      m_max_reg;
    logic [OUT_W-1:0]      m_avg_reg;
    logic [CNT_W-1:0]      m_count_reg;
    logic                  m_pend_reg;

    logic                  accept, stop_beat;
    logic                  div_start, div_done;
    logic [OUT_W-1:0]      div_quo;
    logic                  out_load;
    logic [TIME_WIDTH-1:0] ts_tw, el_cur;
    logic [SUM_W:0]        sum_ext;

    assign accept    = s_valid && s_ready;
    assign stop_beat = accept && s_command;

    // Elapsed time, wrapping in the tick width
    assign ts_tw  = TIME_WIDTH'(s_timestamp);
    assign el_cur = ts_tw - start_reg;

    // Saturating running sum
    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(el_cur);

    // Statistics update
    always_comb begin
        start_next   = start_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        longest_next = longest_reg;
        pend_next    = pend_reg;
        el_next      = el_reg;
        meas_next    = meas_reg;
        if (accept && !s_command) begin
            start_next = ts_tw;
        end else if (stop_beat && pend_reg) begin
            count_next   = '0;
            sum_next     = '0;
            longest_next = '0;
            pend_next    = 1'b0;
            meas_next    = 1'b0;
        end else if (stop_beat) begin
            if (count_reg != '1) begin
                count_next = count_reg + 1'b1;
            end
            sum_next     = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            longest_next = (el_cur > longest_reg) ? el_cur : longest_reg;
            pend_next    = (count_next > limit_reg);
            el_next      = el_cur;
            meas_next    = 1'b1;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (stop_beat) begin
                    state_next = pend_reg ? ST_WRITE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = stop_beat && !pend_reg;
            end
            ST_DIV: begin
                s_ready = 1'b0;
            end
            ST_WRITE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: s_ready = 1'b0;
        endcase
    end

    // Single divider for the average
    lsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Control and statistics state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= LIMIT_RESET;
            start_reg   <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            longest_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            longest_reg <= longest_next;
            pend_reg    <= pend_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Per-beat payload, no reset needed
    always_ff @(posedge aclk) begin
        el_reg   <= el_next;
        meas_reg <= meas_next;
        if (out_load) begin
            m_valid_res_reg <= meas_reg;
            m_elapsed_reg   <= meas_reg ? OUT_W'(el_reg) : '0;
            m_max_reg       <= OUT_W'(longest_reg);
            m_avg_reg       <= meas_reg ? div_quo : '0;
            m_count_reg     <= count_reg;
            m_pend_reg      <= pend_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_valid_res     = m_valid_res_reg;
    assign m_elapsed       = m_elapsed_reg;
    assign m_max_elapsed   = m_max_reg;
    assign m_average       = m_avg_reg;
    assign m_sample_count  = m_count_reg;
    assign m_clear_pending = m_pend_reg;

endmodule : latency_stats_monitor_top

@@ rtl/lsm_div.sv @@
// ============================================================================
// lsm_div - bit-serial unsigned divider
// Restoring division of the running sum by the sample count, one quotient
// bit per cycle. Delivers the low quotient bits with a one-cycle done pulse.
// ============================================================================
module lsm_div
    import lsm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [OUT_W-1:0] quotient
);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [DIV_STEP_W-1:0] step_reg,  step_next;
    logic [CNT_W-1:0]      rem_reg,   rem_next;
    logic [SUM_W-1:0]      quo_reg,   quo_next;
    logic [CNT_W-1:0]      div_reg,   div_next;

    // Shift-subtract datapath: remainder stays below the divisor
    logic [CNT_W:0]   shifted;
    logic [CNT_W+1:0] diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign fits    = ~diff[CNT_W+1];

    // Step control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[OUT_W-1:0];

endmodule : lsm_div

@@ rtl/lsm_checker.sv @@
// ============================================================================
// lsm_checker - port-level checks for the latency statistics monitor
// Watches the top level's ports and flags result beats that break the
// block's rules.
// ============================================================================
module lsm_checker
    import lsm_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_command,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_valid_res,
    input logic [OUT_W-1:0] m_elapsed,
    input logic [OUT_W-1:0] m_max_elapsed,
    input logic [OUT_W-1:0] m_average,
    input logic [CNT_W-1:0] m_sample_count,
    input logic             m_clear_pending
);

    // A stalled result beat holds its flag, elapsed time, average and count
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_valid_res)
            && $stable(m_elapsed) && $stable(m_average)
            && $stable(m_sample_count))
        else $error("result beat changed while stalled");

    // A clearing beat reports all-zero statistics
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_elapsed == '0 && m_max_elapsed == '0
            && m_average == '0 && m_sample_count == '0 && !m_clear_pending)
        else $error("clearing beat carries non-zero fields");

    // A recorded measurement always has a non-zero count
    a_count_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> m_sample_count != '0)
        else $error("measurement with zero count");

    // An accepted stop beat takes s_ready low
    a_stop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command |=> !s_ready)
        else $error("input accepted during stop processing");

endmodule : lsm_checker

bind latency_stats_monitor_top lsm_checker u_lsm_checker (.*);
